// ===== hw/rtl/dsci_pkg.sv =====
// shared constants for the degree sine/cosine interpolator
`default_nettype none

package dsci_pkg;

   localparam int ANGLE_W   = 24;
   localparam int VALUE_W   = 16;
   localparam int DEG_TURN  = 360;
   localparam int TABLE_LEN = DEG_TURN + 1;
   localparam int WHOLE_W   = $clog2(TABLE_LEN);

   // function select codes
   localparam logic MODE_SINE   = 1'b0;
   localparam logic MODE_COSINE = 1'b1;

   // whole turns added so the integer degree count is never negative
   localparam int TURN_COUNT  = (1 << (ANGLE_W - 1)) / DEG_TURN + 1;
   localparam int REDUCE_BIAS = TURN_COUNT * DEG_TURN;
   localparam int BIASED_W    = ANGLE_W + 1;

   // reciprocal of 360 for the modulo reduction
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP       = (1 << RECIP_SHIFT) / DEG_TURN;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int RPROD_W     = BIASED_W + RECIP_W;
   localparam int QUOT_W      = RPROD_W - RECIP_SHIFT;
   // remainder estimate stays below two turns
   localparam int REM_W       = $clog2(2 * DEG_TURN);

endpackage : dsci_pkg

`default_nettype wire

// ===== hw/rtl/dsci_reduce.sv =====
// angle reduction: signed fixed-point degrees to whole degree 0..359 and fraction
`default_nettype none

module dsci_reduce
   import dsci_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int FRAC_W          = (ANGLE_FRAC_BITS > 0) ? ANGLE_FRAC_BITS : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [ANGLE_W-1:0] in_angle,
   input  logic                      in_mode,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [WHOLE_W-1:0]        out_whole,
   output logic [FRAC_W-1:0]         out_frac,
   output logic                      out_mode
);

   // tag carries {mode, fraction} alongside the reduction
   localparam int TAG_W = FRAC_W + 1;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic                      en1, en2, en3, en4;

   logic signed [ANGLE_W-1:0] whole_deg;
   logic signed [BIASED_W:0]  biased;
   logic [FRAC_W-1:0]         frac_sel;

   logic [BIASED_W-1:0]       u1_ff, u1_in, u2_ff;
   logic [TAG_W-1:0]          tag1_ff, tag1_in, tag2_ff, tag3_ff, tag4_ff;
   logic [RPROD_W-1:0]        rprod_ff, rprod_in;
   logic [QUOT_W-1:0]         quot;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [WHOLE_W-1:0]        whole_ff, whole_in;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // floor of angle / 2^frac, then biased positive
   always_comb begin
      whole_deg = in_angle >>> ANGLE_FRAC_BITS;
      biased    = (BIASED_W + 1)'(whole_deg) + (BIASED_W + 1)'(REDUCE_BIAS);
      u1_in     = biased[BIASED_W-1:0];
      frac_sel  = (ANGLE_FRAC_BITS == 0) ? '0 : in_angle[FRAC_W-1:0];
      tag1_in   = {in_mode, frac_sel};
   end

   assign rprod_in = RPROD_W'(u1_ff) * RPROD_W'(RECIP);

   // quotient estimate can be one low, fixed up in the next stage
   always_comb begin
      quot   = rprod_ff[RPROD_W-1:RECIP_SHIFT];
      rem_in = REM_W'(u2_ff - BIASED_W'(quot) * BIASED_W'(DEG_TURN));
   end

   assign whole_in = (rem_ff >= REM_W'(DEG_TURN)) ? WHOLE_W'(rem_ff - REM_W'(DEG_TURN))
                                                   : WHOLE_W'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         u1_ff   <= u1_in;
         tag1_ff <= tag1_in;
      end
      if (en2) begin
         rprod_ff <= rprod_in;
         u2_ff    <= u1_ff;
         tag2_ff  <= tag1_ff;
      end
      if (en3) begin
         rem_ff  <= rem_in;
         tag3_ff <= tag2_ff;
      end
      if (en4) begin
         whole_ff <= whole_in;
         tag4_ff  <= tag3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_whole = whole_ff;
   assign out_frac  = tag4_ff[FRAC_W-1:0];
   assign out_mode  = tag4_ff[FRAC_W];

endmodule : dsci_reduce

`default_nettype wire

// ===== hw/rtl/dsci_rom.sv =====
// sine and cosine tables with a registered two-entry read
`default_nettype none

module dsci_rom
   import dsci_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 14,
   parameter int ROM_W         = OUT_FRAC_BITS + 2,
   parameter int FRAC_W        = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [WHOLE_W-1:0]      in_whole,
   input  logic [FRAC_W-1:0]       in_frac,
   input  logic                    in_mode,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [ROM_W-1:0] out_lo,
   output logic signed [ROM_W-1:0] out_hi,
   output logic [FRAC_W-1:0]       out_frac
);

   typedef logic signed [ROM_W-1:0] rom_type [TABLE_LEN];

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // first quadrant sine by truncated series in Q2.30, rounded half up to OUT_FRAC_BITS
   function automatic logic [31:0] quadrant_sine(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      int unsigned sh;
      logic        neg;
      neg = 1'b1;
      if (k == 0) return 32'd0;
      if (k >= 90) return 32'(64'd1 << OUT_FRAC_BITS);
      x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (neg) sum = sum - term;
         else sum = sum + term;
         neg = !neg;
      end
      sh = 30 - OUT_FRAC_BITS;
      if (sh > 0) sum = (sum + (64'd1 << (sh - 1))) >> sh;
      return sum[31:0];
   endfunction

   function automatic logic signed [31:0] full_sine(input int unsigned k);
      int unsigned kk;
      kk = k % DEG_TURN;
      if (kk <= 90)  return $signed(quadrant_sine(kk));
      if (kk <= 180) return $signed(quadrant_sine(180 - kk));
      if (kk <= 270) return -$signed(quadrant_sine(kk - 180));
      return -$signed(quadrant_sine(DEG_TURN - kk));
   endfunction

   function automatic rom_type build_rom(input logic cos_sel);
      rom_type tbl;
      for (int unsigned k = 0; k < TABLE_LEN; k++) begin
         tbl[k] = ROM_W'(full_sine(cos_sel ? k + 90 : k));
      end
      return tbl;
   endfunction

   localparam rom_type SINE_ROM   = build_rom(MODE_SINE);
   localparam rom_type COSINE_ROM = build_rom(MODE_COSINE);

   logic                    valid_ff;
   logic                    en;
   logic [WHOLE_W-1:0]      next_whole;
   logic signed [ROM_W-1:0] lo_ff, hi_ff;
   logic [FRAC_W-1:0]       frac_ff;

   assign en         = !valid_ff || out_ready;
   assign in_ready   = en;
   assign next_whole = in_whole + WHOLE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (in_mode == MODE_COSINE) begin
            lo_ff <= COSINE_ROM[in_whole];
            hi_ff <= COSINE_ROM[next_whole];
         end else begin
            lo_ff <= SINE_ROM[in_whole];
            hi_ff <= SINE_ROM[next_whole];
         end
         frac_ff <= in_frac;
      end
   end

   assign out_valid = valid_ff;
   assign out_lo    = lo_ff;
   assign out_hi    = hi_ff;
   assign out_frac  = frac_ff;

endmodule : dsci_rom

`default_nettype wire

// ===== hw/rtl/dsci_interp.sv =====
// linear interpolation between two table entries, product truncated toward zero
`default_nettype none

module dsci_interp
   import dsci_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int ROM_W           = 16,
   parameter int FRAC_W          = (ANGLE_FRAC_BITS > 0) ? ANGLE_FRAC_BITS : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [ROM_W-1:0]   in_lo,
   input  logic signed [ROM_W-1:0]   in_hi,
   input  logic [FRAC_W-1:0]         in_frac,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [VALUE_W-1:0] out_value
);

   localparam int DIFF_W    = ROM_W + 1;
   localparam int MUL_W     = DIFF_W + FRAC_W + 1;
   localparam int SUM_W     = ((MUL_W > VALUE_W) ? MUL_W : VALUE_W) + 1;
   localparam int FRAC_MASK = (1 << ANGLE_FRAC_BITS) - 1;

   logic                      v1_ff, v2_ff, v3_ff;
   logic                      en1, en2, en3;

   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [ROM_W-1:0]   base1_ff, base2_ff;
   logic [FRAC_W-1:0]         frac1_ff;
   logic signed [MUL_W-1:0]   mul_ff, mul_in;
   logic signed [MUL_W-1:0]   adj;
   logic signed [MUL_W-1:0]   step;
   logic signed [SUM_W-1:0]   total;
   logic signed [VALUE_W-1:0] value_ff, value_in;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign diff_in = DIFF_W'(in_hi) - DIFF_W'(in_lo);
   assign mul_in  = MUL_W'(diff_ff) * MUL_W'($signed({1'b0, frac1_ff}));

   // bias negative products so the shift rounds toward zero
   always_comb begin
      adj      = mul_ff + (mul_ff[MUL_W-1] ? MUL_W'(FRAC_MASK) : MUL_W'(0));
      step     = adj >>> ANGLE_FRAC_BITS;
      total    = SUM_W'(base2_ff) + SUM_W'(step);
      value_in = total[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         diff_ff  <= diff_in;
         base1_ff <= in_lo;
         frac1_ff <= in_frac;
      end
      if (en2) begin
         mul_ff   <= mul_in;
         base2_ff <= base1_ff;
      end
      if (en3) begin
         value_ff <= value_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_value = value_ff;

endmodule : dsci_interp

`default_nettype wire

// ===== hw/rtl/degree_sine_cosine_interp.sv =====
// Sine or cosine of a signed fixed-point angle in degrees, by table lookup
// with linear interpolation. While rsp_ready is high, every clock one
// transaction can enter and one can leave. The eight stages are: bias of
// the whole degree count, reciprocal multiply by 1/360, remainder estimate,
// remainder correction, registered two-entry table read, entry difference,
// fraction multiply, and the truncating shift and add into the output
// register. The multiplies and the table read each own a stage and set the
// clock budget. Both 361-entry tables are built at elaboration from
// OUT_FRAC_BITS, so no load sequence follows reset. With OUT_FRAC_BITS above
// 14 rsp_value holds the low 16 bits of the result.
`default_nettype none

module degree_sine_cosine_interp
   import dsci_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int OUT_FRAC_BITS   = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [ANGLE_W-1:0] req_angle,
   input  logic                      req_mode,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value
);

   localparam int FRAC_W = (ANGLE_FRAC_BITS > 0) ? ANGLE_FRAC_BITS : 1;
   localparam int ROM_W  = OUT_FRAC_BITS + 2;

   logic                    red_valid, red_ready;
   logic [WHOLE_W-1:0]      red_whole;
   logic [FRAC_W-1:0]       red_frac;
   logic                    red_mode;

   logic                    rom_valid, rom_ready;
   logic signed [ROM_W-1:0] rom_lo, rom_hi;
   logic [FRAC_W-1:0]       rom_frac;

   dsci_reduce #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .FRAC_W          (FRAC_W)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_angle  (req_angle),
      .in_mode   (req_mode),
      .out_valid (red_valid),
      .out_ready (red_ready),
      .out_whole (red_whole),
      .out_frac  (red_frac),
      .out_mode  (red_mode)
   );

   dsci_rom #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .ROM_W         (ROM_W),
      .FRAC_W        (FRAC_W)
   ) u_rom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_whole  (red_whole),
      .in_frac   (red_frac),
      .in_mode   (red_mode),
      .out_valid (rom_valid),
      .out_ready (rom_ready),
      .out_lo    (rom_lo),
      .out_hi    (rom_hi),
      .out_frac  (rom_frac)
   );

   dsci_interp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .ROM_W           (ROM_W),
      .FRAC_W          (FRAC_W)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rom_valid),
      .in_ready  (rom_ready),
      .in_lo     (rom_lo),
      .in_hi     (rom_hi),
      .in_frac   (rom_frac),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_value (rsp_value)
   );

endmodule : degree_sine_cosine_interp

`default_nettype wire

// ===== hw/rtl/dsci_checker.sv =====
// port-level checks for the degree sine/cosine interpolator, bound to the top level
`default_nettype none

module dsci_checker
   import dsci_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 14
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_value
);

   localparam int FULL_SCALE = (OUT_FRAC_BITS <= 14) ? (1 << OUT_FRAC_BITS) : 0;

   // no transaction on the response side right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a draining output means every stage can move, so a request is taken
   a_ready_flows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while the output drains");

   // interpolated value never leaves the unit range
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (OUT_FRAC_BITS <= 14) |->
         (rsp_value >= -FULL_SCALE) && (rsp_value <= FULL_SCALE))
      else $error("result outside unit range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("stalled response changed");

endmodule : dsci_checker

bind degree_sine_cosine_interp dsci_checker #(
   .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_dsci_checker (.*);

`default_nettype wire

// ===== dv/degree_sine_cosine_interp_test.sv =====
// self-checking testbench for the degree sine/cosine interpolator
`default_nettype none

module degree_sine_cosine_interp_test
   import dsci_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_FRAC_BITS = 8;
   localparam int OUT_FRAC_BITS   = 14;
   localparam int RANDOM_ITEMS    = 1500;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 32;
   localparam int PRESSURE_AT     = 400;
   localparam int PRESSURE_HOLD   = 300;
   localparam int NUM_DIRECTED    = 21;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam int DEG90 = 90 << ANGLE_FRAC_BITS;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic                      mode;
      logic                      known;
      logic signed [VALUE_W-1:0] value;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [ANGLE_W-1:0] req_angle = '0;
   logic                      req_mode = MODE_SINE;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value;

   logic signed [VALUE_W-1:0] value_q [$];
   int sine_tab   [TABLE_LEN];
   int cosine_tab [TABLE_LEN];
   int err_count      = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int cosine_count   = 0;
   int negative_count = 0;
   int cycle_count    = 0;

   // expected value in the exact column only where it is obvious
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{24'sd0,           MODE_SINE,   1'b1, 16'sd0},
      '{24'sd0,           MODE_COSINE, 1'b1, 16'sd16384},
      '{24'sd23040,       MODE_SINE,   1'b1, 16'sd16384},
      '{24'sd23040,       MODE_COSINE, 1'b1, 16'sd0},
      '{24'sd46080,       MODE_SINE,   1'b1, 16'sd0},
      '{24'sd46080,       MODE_COSINE, 1'b1, -16'sd16384},
      '{24'sd69120,       MODE_SINE,   1'b1, -16'sd16384},
      '{24'sd92160,       MODE_SINE,   1'b1, 16'sd0},
      '{-24'sd23040,      MODE_SINE,   1'b1, -16'sd16384},
      '{-24'sd46080,      MODE_COSINE, 1'b1, -16'sd16384},
      '{24'sh7FFFFF,      MODE_SINE,   1'b0, 16'sd0},
      '{24'sh7FFFFF,      MODE_COSINE, 1'b0, 16'sd0},
      '{24'sh800000,      MODE_SINE,   1'b0, 16'sd0},
      '{24'sh800000,      MODE_COSINE, 1'b0, 16'sd0},
      '{-24'sd1,          MODE_SINE,   1'b0, 16'sd0},
      '{-24'sd1,          MODE_COSINE, 1'b0, 16'sd0},
      '{24'sd255,         MODE_SINE,   1'b0, 16'sd0},
      '{24'sd92159,       MODE_COSINE, 1'b0, 16'sd0},
      '{24'sd128,         MODE_SINE,   1'b0, 16'sd0},
      '{24'sd91904,       MODE_COSINE, 1'b0, 16'sd0},
      '{24'sd25677,       MODE_SINE,   1'b0, 16'sd0}
   };

   degree_sine_cosine_interp #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .OUT_FRAC_BITS  (OUT_FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_angle(req_angle),
      .req_mode (req_mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_value(rsp_value)
   );

   always #5 clock = ~clock;

   // first quadrant sine: q2.30 taylor series, rounded to the output format
   function automatic int quarter_sine(int unsigned k);
      longint unsigned x, x2, term, sum, k64, div;
      bit neg;
      int unsigned sh;
      if (k == 0) return 0;
      if (k >= 90) return 1 << OUT_FRAC_BITS;
      k64 = k;
      x = (k64 * PI_Q30 + 64'd90) / 64'd180;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      neg = 1'b1;
      for (int n = 1; n <= 7; n++) begin
         div = longint'((2 * n) * (2 * n + 1));
         term = ((term * x2) >> 30) / div;
         if (neg) sum = sum - term;
         else sum = sum + term;
         neg = ~neg;
      end
      sh = 30 - OUT_FRAC_BITS;
      if (sh > 0) sum = (sum + (64'd1 << (sh - 1))) >> sh;
      return int'(sum);
   endfunction

   function automatic int degree_sine(int unsigned k);
      k = k % DEG_TURN;
      if (k <= 90) return quarter_sine(k);
      if (k <= 180) return quarter_sine(180 - k);
      if (k <= 270) return -quarter_sine(k - 180);
      return -quarter_sine(360 - k);
   endfunction

   function automatic logic signed [VALUE_W-1:0] interp_value(
      logic signed [ANGLE_W-1:0] angle, logic mode);
      int a, turn, r, w, f, lo, hi, v;
      a = int'(angle);
      turn = DEG_TURN << ANGLE_FRAC_BITS;
      r = a % turn;
      if (r < 0) r = r + turn;
      w = r >> ANGLE_FRAC_BITS;
      f = r & ((1 << ANGLE_FRAC_BITS) - 1);
      if (w > DEG_TURN - 1) w = DEG_TURN - 1;
      if (mode == MODE_COSINE) begin
         lo = cosine_tab[w];
         hi = cosine_tab[w + 1];
      end else begin
         lo = sine_tab[w];
         hi = sine_tab[w + 1];
      end
      // signed division truncates toward zero
      v = lo + ((hi - lo) * f) / (1 << ANGLE_FRAC_BITS);
      return v[VALUE_W-1:0];
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one transaction, hold it until taken, then idle for gap cycles
   task automatic send_angle(logic signed [ANGLE_W-1:0] angle, logic mode,
                             logic known, logic signed [VALUE_W-1:0] value,
                             int gap);
      req_valid <= 1'b1;
      req_angle <= angle;
      req_mode  <= mode;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      value_q.push_back(known ? value : interp_value(angle, mode));
      accepted_count++;
      if (mode == MODE_COSINE) cosine_count++;
      if (angle < 0) negative_count++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[degree_sine_cosine_interp] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (value_q.size() == 0) begin
            $error("unexpected result, value %0d", rsp_value);
            err_count++;
         end else begin
            if (rsp_value !== value_q[0]) begin
               $error("value mismatch: expected %0d, actual %0d", value_q[0], rsp_value);
               err_count++;
            end
            void'(value_q.pop_front());
            checked_count++;
         end
      end
   end

   // receiver: random ready, bursts of ready, short hold-offs and one long hold-off
   initial begin
      int unsigned r;
      int hold_left, burst_left;
      bit pressure_done;
      hold_left = 0;
      burst_left = 0;
      pressure_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && accepted_count >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_HOLD;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_ready <= 1'b1;
            burst_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               burst_left = $urandom_range(30, 120);
               rsp_ready <= 1'b1;
            end else if (r < 5) begin
               hold_left = $urandom_range(10, 40);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= (r < 75);
            end
         end
      end
   end

   initial begin
      int unsigned pick;
      logic signed [ANGLE_W-1:0] angle;
      int gap;
      for (int k = 0; k < TABLE_LEN; k++) begin
         sine_tab[k]   = degree_sine(k);
         cosine_tab[k] = degree_sine(k + 90);
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_angle(directed_rows[i].angle, directed_rows[i].mode, directed_rows[i].known,
                    directed_rows[i].value, pick_gap());

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            angle = ANGLE_W'($urandom);
         end else if (pick < 75) begin
            // close to a quadrant boundary, within 93 quadrants either side of zero
            angle = ANGLE_W'(($signed($urandom_range(0, 186)) - 93) * DEG90
                             + $signed($urandom_range(0, 600)) - 300);
         end else if (pick < 90) begin
            angle = ANGLE_W'($signed($urandom_range(0, 4 * 92160)) - 2 * 92160);
         end else if (pick < 95) begin
            angle = ANGLE_W'(24'sh7FFFFF - $urandom_range(0, 1000));
         end else begin
            angle = ANGLE_W'(24'sh800000 + $urandom_range(0, 1000));
         end
         // a stretch of back-to-back transactions every so often
         gap = ((i / 128) % 4 == 1) ? 0 : pick_gap();
         send_angle(angle, 1'($urandom_range(0, 1)), 1'b0, '0, gap);
      end
      req_valid <= 1'b0;

      while (value_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (value_q.size() != 0) begin
         $error("%0d expected results never arrived", value_q.size());
         err_count++;
      end
      $display("ran %0d transactions: %0d cosine, %0d negative angles, incl. range extremes",
               accepted_count, cosine_count, negative_count);
      $display("checked %0d results with random stalls and one long receiver hold-off",
               checked_count);
      if (err_count == 0) begin
         $display("[degree_sine_cosine_interp] OK");
      end else begin
         $display("[degree_sine_cosine_interp] ERROR");
      end
      $finish;
   end

endmodule : degree_sine_cosine_interp_test

`default_nettype wire
